@@ src/rhsm_pkg.sv @@
package rhsm_pkg;

  // Hash arithmetic
  localparam int HASH_W = 30;
  localparam int PROD_W = 2 * HASH_W;
  localparam int CODE_W = 7;
  localparam int OUT_W  = 16;

  localparam logic [HASH_W-1:0] HASH_MOD  = 30'd1000000007;
  localparam logic [HASH_W-1:0] HASH_BASE = 30'd31;

  // Barrett constant floor(2^60 / HASH_MOD), fits in 31 bits
  localparam logic [63:0] BARRETT_MU_64 = (64'd1 << PROD_W) / {34'd0, HASH_MOD};
  localparam logic [30:0] BARRETT_MU    = BARRETT_MU_64[30:0];

  // Input function codes
  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_PATTERN = 2'd1;
  localparam logic [1:0] FUNC_TEXT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_PATTERN,
    KIND_TEXT
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [HASH_W-1:0] value;
  } item_t;

  // Tags of the products issued to the modular multiplier
  typedef enum logic [1:0] {
    OP_VALUE,
    OP_POWER,
    OP_SCALE
  } op_tag_t;

  typedef struct packed {
    logic              valid;
    op_tag_t           tag;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              valid;
    op_tag_t           tag;
    logic [HASH_W-1:0] result;
  } mm_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ISSUE,
    B_WAIT,
    B_SUM,
    B_DONE
  } back_state_t;

endpackage

@@ src/rhsm_ram.sv @@
module rhsm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rhsm_mulmod.sv @@
module rhsm_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  rhsm_pkg::mm_req_t req,
  output rhsm_pkg::mm_rsp_t rsp
);

  import rhsm_pkg::*;

  localparam int STAGES = 6;

  logic    vld [STAGES];
  op_tag_t tag [STAGES];

  logic [PROD_W-1:0]   s1_prod;
  logic [61:0]         s2_est;
  logic [31:0]         s2_prod_lo;
  logic [31:0]         s3_qp_lo;
  logic [31:0]         s3_prod_lo;
  logic [31:0]         s4_rem;
  logic [31:0]         s5_rem;
  logic [HASH_W-1:0]   s6_res;
  logic [30:0]         quot;

  assign quot = s2_est[61:31];

  // Shift valid and tag along the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= req.valid;
      for (int i = 1; i < STAGES; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= req.tag;
    for (int i = 1; i < STAGES; i++) begin
      tag[i] <= tag[i-1];
    end
  end

  // Full product, Barrett estimate, quotient times modulus, then two corrections
  always_ff @(posedge clk) begin
    s1_prod    <= PROD_W'(req.a) * PROD_W'(req.b);
    s2_est     <= 62'(s1_prod[59:29]) * 62'(BARRETT_MU);
    s2_prod_lo <= s1_prod[31:0];
    s3_qp_lo   <= 32'(quot) * 32'(HASH_MOD);
    s3_prod_lo <= s2_prod_lo;
    s4_rem     <= s3_prod_lo - s3_qp_lo;
    s5_rem     <= (s4_rem >= 32'(HASH_MOD)) ? s4_rem - 32'(HASH_MOD) : s4_rem;
    s6_res     <= (s5_rem >= 32'(HASH_MOD)) ? HASH_W'(s5_rem - 32'(HASH_MOD))
                                            : HASH_W'(s5_rem);
  end

  assign rsp.valid  = vld[STAGES-1];
  assign rsp.tag    = tag[STAGES-1];
  assign rsp.result = s6_res;

  // A reduced product is always a proper residue
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.result < HASH_MOD))
    else $error("modular product not fully reduced");

endmodule

@@ src/rhsm_front.sv @@
module rhsm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [6:0] letter, [7] zero
  input  logic [1:0]      s_axis_tuser,   // [1:0] func
  output logic            q_valid,
  input  logic            q_pop,
  output rhsm_pkg::item_t q_item
);

  import rhsm_pkg::*;

  item_t      entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       keep;
  logic       push;
  logic       pop;
  item_t      incoming;

  function automatic logic [HASH_W-1:0] letter_value(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] offset;
    offset = 7'd96;
    if (code >= offset) begin
      return HASH_W'(code - offset);
    end
    // Codes below the offset wrap to a residue just under the modulus
    return HASH_MOD - HASH_W'(offset - code);
  endfunction

  // Classify the incoming transaction, drop unused function codes
  always_comb begin
    incoming.value = letter_value(s_axis_tdata[CODE_W-1:0]);
    unique case (s_axis_tuser)
      FUNC_CLEAR: begin
        incoming.kind = KIND_CLEAR;
        keep          = 1'b1;
      end
      FUNC_PATTERN: begin
        incoming.kind = KIND_PATTERN;
        keep          = 1'b1;
      end
      FUNC_TEXT: begin
        incoming.kind = KIND_TEXT;
        keep          = 1'b1;
      end
      default: begin
        incoming.kind = KIND_CLEAR;
        keep          = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign q_valid       = (count != 2'd0);
  assign pop           = q_pop && q_valid;
  assign q_item        = entries[rd_ptr];

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

endmodule

@@ src/rhsm_back.sv @@
module rhsm_back #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  rhsm_pkg::item_t           q_item,
  output rhsm_pkg::mm_req_t         mm_req,
  input  rhsm_pkg::mm_rsp_t         mm_rsp,
  output logic                      ring_we,
  output logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] ring_waddr,
  output logic [rhsm_pkg::HASH_W-1:0] ring_wdata,
  output logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] ring_raddr,
  input  logic [rhsm_pkg::HASH_W-1:0] ring_rdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [rhsm_pkg::OUT_W-1:0] m_axis_tdata
);

  import rhsm_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS + 1;
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam logic [LEN_W:0]   MAX_EXT  = (LEN_W + 1)'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PATTERN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PATTERN - 1);

  back_state_t state, state_next;
  op_tag_t     op, op_next;
  op_tag_t     last_op;
  logic [1:0]  recv;
  logic [1:0]  need;
  item_t       item;
  logic        is_pattern;

  logic [HASH_W-1:0] r_value;
  logic [HASH_W-1:0] r_power;
  logic [HASH_W-1:0] r_scale;
  logic [HASH_W-1:0] sum;

  logic [HASH_W-1:0] pattern_hash;
  logic [LEN_W-1:0]  pattern_length;
  logic [HASH_W-1:0] pattern_power;
  logic              pattern_overflow;
  logic [HASH_W-1:0] text_prefix;
  logic [HASH_W-1:0] text_power;
  logic [HASH_W-1:0] scaled_pattern;
  logic [POS_W-1:0]  text_position;
  logic [IDX_W-1:0]  wp;

  logic              out_valid;
  logic [OUT_W-1:0]  out_data;
  logic              out_free;

  logic [LEN_W:0]    wp_ext;
  logic [LEN_W:0]    len_ext;
  logic [CMP_W-1:0]  t_plus;
  logic [CMP_W-1:0]  m_cmp;
  logic [CMP_W-1:0]  start;
  logic              first_window;
  logic              in_window;
  logic [HASH_W-1:0] window;
  logic [HASH_W-1:0] scaled_new;
  logic              match;
  logic [HASH_W-1:0] sum_in;
  logic [HASH_W:0]   sum_wide;
  logic              finish;

  assign is_pattern = (item.kind == KIND_PATTERN);
  assign need       = is_pattern ? 2'd2 : 2'd3;
  assign last_op    = is_pattern ? OP_POWER : OP_SCALE;
  assign out_free   = !out_valid || m_axis_tready;
  assign finish     = (state == B_DONE) && out_free;

  // Ring slot of the prefix just before the window start
  assign wp_ext  = (LEN_W + 1)'(wp);
  assign len_ext = (LEN_W + 1)'(pattern_length);
  assign ring_raddr = (wp_ext >= len_ext) ? IDX_W'(wp_ext - len_ext)
                                          : IDX_W'(wp_ext + MAX_EXT - len_ext);

  // Hash addition modulo P
  assign sum_in   = is_pattern ? pattern_hash : text_prefix;
  assign sum_wide = (HASH_W + 1)'(sum_in) + (HASH_W + 1)'(r_value);

  // Window test for the finished text letter
  assign t_plus       = CMP_W'(text_position) + CMP_W'(1);
  assign m_cmp        = CMP_W'(pattern_length);
  assign start        = t_plus - m_cmp;
  assign first_window = (t_plus == m_cmp);
  assign in_window    = (pattern_length != '0) && !pattern_overflow && (t_plus >= m_cmp);
  assign scaled_new   = first_window ? pattern_hash : r_scale;
  always_comb begin
    if (first_window) begin
      window = sum;
    end else if (sum >= ring_rdata) begin
      window = sum - ring_rdata;
    end else begin
      window = HASH_W'((HASH_W + 1)'(sum) + (HASH_W + 1)'(HASH_MOD)
                       - (HASH_W + 1)'(ring_rdata));
    end
  end
  assign match = in_window && (window == scaled_new);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            KIND_PATTERN: if (pattern_length < MAX_LEN) state_next = B_ISSUE;
            KIND_TEXT:    if (!text_position[POSITION_BITS]) state_next = B_ISSUE;
            default:      state_next = B_IDLE;
          endcase
        end
      end
      B_ISSUE: if (op == last_op) state_next = B_WAIT;
      B_WAIT:  if (recv == need) state_next = B_SUM;
      B_SUM:   state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_VALUE: op_next = OP_POWER;
      OP_POWER: op_next = OP_SCALE;
      default:  op_next = OP_SCALE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    mm_req     = '0;
    mm_req.tag = op;
    ring_we    = 1'b0;
    ring_waddr = wp;
    ring_wdata = sum;
    unique case (state)
      B_IDLE:  q_pop = q_valid;
      B_ISSUE: begin
        mm_req.valid = 1'b1;
        unique case (op)
          OP_VALUE: begin
            mm_req.a = item.value;
            mm_req.b = is_pattern ? pattern_power : text_power;
          end
          OP_POWER: begin
            mm_req.a = is_pattern ? pattern_power : text_power;
            mm_req.b = HASH_BASE;
          end
          default: begin
            mm_req.a = scaled_pattern;
            mm_req.b = HASH_BASE;
          end
        endcase
      end
      B_DONE:  ring_we = out_free && !is_pattern;
      default: q_pop = 1'b0;
    endcase
  end

  // Control and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= B_IDLE;
      op               <= OP_VALUE;
      recv             <= 2'd0;
      pattern_hash     <= '0;
      pattern_length   <= '0;
      pattern_power    <= HASH_W'(1);
      pattern_overflow <= 1'b0;
      text_prefix      <= '0;
      text_power       <= HASH_W'(1);
      scaled_pattern   <= '0;
      text_position    <= '0;
      wp               <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      unique case (state)
        B_IDLE: begin
          op   <= OP_VALUE;
          recv <= 2'd0;
          if (q_valid) begin
            unique case (q_item.kind)
              KIND_CLEAR: begin
                pattern_hash     <= '0;
                pattern_length   <= '0;
                pattern_power    <= HASH_W'(1);
                pattern_overflow <= 1'b0;
                text_prefix      <= '0;
                text_power       <= HASH_W'(1);
                scaled_pattern   <= '0;
                text_position    <= '0;
                wp               <= '0;
              end
              KIND_PATTERN: begin
                // Too long: mark overflow and restart the text here
                if (pattern_length >= MAX_LEN) begin
                  pattern_overflow <= 1'b1;
                  text_prefix      <= '0;
                  text_power       <= HASH_W'(1);
                  scaled_pattern   <= '0;
                  text_position    <= '0;
                  wp               <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        B_ISSUE: op <= op_next;
        B_DONE: begin
          if (out_free) begin
            if (is_pattern) begin
              pattern_hash   <= sum;
              pattern_power  <= r_power;
              pattern_length <= pattern_length + LEN_W'(1);
              text_prefix    <= '0;
              text_power     <= HASH_W'(1);
              scaled_pattern <= '0;
              text_position  <= '0;
              wp             <= '0;
            end else begin
              text_prefix   <= sum;
              text_power    <= r_power;
              text_position <= text_position + POS_W'(1);
              wp            <= (wp == LAST_IDX) ? '0 : wp + IDX_W'(1);
              if (in_window) begin
                scaled_pattern <= scaled_new;
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Raise the output on a match, drop it once the consumer takes it
      if (finish && !is_pattern && match) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // Count returning products
      if (mm_rsp.valid) begin
        recv <= recv + 2'd1;
      end
    end
  end

  // Latch the item, products, sum and result payload
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      item <= q_item;
    end
    if (mm_rsp.valid) begin
      unique case (mm_rsp.tag)
        OP_VALUE: r_value <= mm_rsp.result;
        OP_POWER: r_power <= mm_rsp.result;
        default:  r_scale <= mm_rsp.result;
      endcase
    end
    if (state == B_SUM) begin
      sum <= (sum_wide >= (HASH_W + 1)'(HASH_MOD))
             ? HASH_W'(sum_wide - (HASH_W + 1)'(HASH_MOD)) : HASH_W'(sum_wide);
    end
    if (finish && !is_pattern && match) begin
      out_data <= OUT_W'(start);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Products only come back while the sequencer waits for them
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (rst)
    mm_rsp.valid |-> (state == B_WAIT))
    else $error("multiplier result arrived outside the wait phase");

  // The position stops exactly at the limit
  a_position_cap: assert property (@(posedge clk) disable iff (rst)
    text_position[POSITION_BITS] |-> (text_position[POSITION_BITS-1:0] == '0))
    else $error("text position ran past its limit");

  // Pattern length never passes the ring depth
  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= MAX_LEN)
    else $error("pattern length beyond the ring depth");

  // A finished text letter always advances the position
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    (finish && !is_pattern) |=> (text_position == $past(text_position) + POS_W'(1)))
    else $error("text position did not advance");

endmodule

@@ src/rolling_hash_substring_matcher.sv @@
// Letters are handled one at a time, a clear needs no products; a two-entry queue in front takes input meanwhile.
// The three (text) or two (pattern) products go back to back through one shared
// six-stage modular multiplier, and the next letter waits for the last of them.
// Reset: synchronous rst clears all hash state, the input queue and the output register.
// The prefix ring memory is not cleared; only entries written since the last restart are read.
module rolling_hash_substring_matcher #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] letter, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] match_start
);

  import rhsm_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic              q_valid;
  logic              q_pop;
  item_t             q_item;
  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;
  logic [HASH_W-1:0] ring_wdata;
  logic [IDX_W-1:0]  ring_raddr;
  logic [HASH_W-1:0] ring_rdata;

  // Accept and classify
  rhsm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  // Hash updates and window compare
  rhsm_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .mm_req        (mm_req),
    .mm_rsp        (mm_rsp),
    .ring_we       (ring_we),
    .ring_waddr    (ring_waddr),
    .ring_wdata    (ring_wdata),
    .ring_raddr    (ring_raddr),
    .ring_rdata    (ring_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shared modular multiplier
  rhsm_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // Ring of recent text prefixes
  rhsm_ram #(
    .WIDTH (HASH_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

endmodule

@@ tb/match_start_checker.sv @@
module match_start_checker #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] letter, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [15:0] match_start
  output int          mismatch_count,
  output int          results_due
);

  import rhsm_pkg::*;

  localparam bit [63:0]   HASH_P      = 64'd1000000007;
  localparam bit [63:0]   HASH_B      = 64'd31;
  localparam logic [6:0]  LETTER_BIAS = 7'd96;

  // Predicted hash state
  bit [63:0] pat_hash;
  bit [63:0] pat_len;
  bit [63:0] pat_pow;
  bit        pat_overflow;
  bit [63:0] txt_prefix;
  bit [63:0] txt_pow;
  bit [63:0] scaled_pat;
  bit [63:0] txt_pos;
  bit [63:0] prefix_hist [MAX_PATTERN];

  // Match starts still owed by the block, oldest first
  logic [15:0] starts_due [$];

  function automatic bit [63:0] mod_product(bit [63:0] a, bit [63:0] b);
    return (a * b) % HASH_P;
  endfunction

  task automatic restart_text();
    txt_prefix = '0;
    txt_pow    = 64'd1;
    scaled_pat = '0;
    txt_pos    = '0;
  endtask

  task automatic clear_hashes();
    pat_hash     = '0;
    pat_len      = '0;
    pat_pow      = 64'd1;
    pat_overflow = 1'b0;
    restart_text();
    foreach (prefix_hist[i]) prefix_hist[i] = '0;
  endtask

  // Advance the predicted state by one transaction and queue any match start
  task automatic advance_hashes(input logic [1:0] func, input logic [6:0] code);
    bit [63:0] v;
    bit [63:0] prefix_new;
    bit [63:0] old_prefix;
    bit [63:0] window;
    if (code >= LETTER_BIAS)
      v = 64'(code) - 64'(LETTER_BIAS);
    else
      v = HASH_P + 64'(code) - 64'(LETTER_BIAS);
    case (func)
      FUNC_CLEAR: begin
        clear_hashes();
      end
      FUNC_PATTERN: begin
        restart_text();
        if (pat_len >= MAX_PATTERN) begin
          pat_overflow = 1'b1;
        end else begin
          pat_hash = (pat_hash + mod_product(v, pat_pow)) % HASH_P;
          pat_pow  = mod_product(pat_pow, HASH_B);
          pat_len  = pat_len + 1;
        end
      end
      FUNC_TEXT: begin
        // letters past the position limit are dropped
        if (txt_pos < (64'd1 << POSITION_BITS)) begin
          prefix_new = (txt_prefix + mod_product(v, txt_pow)) % HASH_P;
          old_prefix = '0;
          if (pat_len != 0 && txt_pos >= pat_len)
            old_prefix = prefix_hist[(txt_pos - pat_len) % MAX_PATTERN];
          if (pat_len != 0 && !pat_overflow && txt_pos + 1 >= pat_len) begin
            if (txt_pos + 1 == pat_len) begin
              scaled_pat = pat_hash;
              window     = prefix_new;
            end else begin
              scaled_pat = mod_product(scaled_pat, HASH_B);
              window     = (prefix_new + HASH_P - old_prefix) % HASH_P;
            end
            if (window == scaled_pat)
              starts_due.push_back(16'(txt_pos + 1 - pat_len));
          end
          prefix_hist[txt_pos % MAX_PATTERN] = prefix_new;
          txt_prefix = prefix_new;
          txt_pow    = mod_product(txt_pow, HASH_B);
          txt_pos    = txt_pos + 1;
        end
      end
      default: ;
    endcase
  endtask

  // Compare each result transaction, then predict from each input transaction
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      clear_hashes();
      starts_due.delete();
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (starts_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("match_start mismatch at %0t: expected none, got %0d",
                     $realtime, m_axis_tdata);
        end else begin
          want = starts_due.pop_front();
          if (m_axis_tdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("match_start mismatch at %0t: expected %0d, got %0d",
                       $realtime, want, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        advance_hashes(s_axis_tuser, s_axis_tdata[6:0]);
    end
    results_due = starts_due.size();
  end

endmodule

@@ tb/rolling_hash_substring_matcher_test.sv @@
module rolling_hash_substring_matcher_test;
  import rhsm_pkg::*;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 16;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [6:0] CODE_A      = 7'd97;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [6:0] letter, [7] zero
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] match_start

  int          mismatch_count;
  int          results_due;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;

  rolling_hash_substring_matcher #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  match_start_checker #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hold off at random, then present one transaction until it is taken
  task automatic send_item(input logic [1:0] func, input logic [6:0] letter);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {1'b0, letter};
    do @(posedge clk); while (!s_axis_tready);
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  function automatic logic [6:0] pick_letter(int unsigned alphabet);
    return CODE_A + 7'($urandom_range(alphabet - 1));
  endfunction

  // One random sequence: mostly a pattern followed by text seeded with it
  task automatic run_sequence();
    int unsigned r;
    int unsigned plen;
    int unsigned tlen;
    int unsigned n;
    int unsigned alphabet;
    logic [6:0]  pattern_codes [$];
    logic [6:0]  c;
    r = $urandom_range(99);
    if (r < 70) begin
      if ($urandom_range(1)) send_item(FUNC_CLEAR, 7'($urandom_range(127)));
      alphabet = ($urandom_range(3) == 0) ? 26 : $urandom_range(2, 3);
      r = $urandom_range(99);
      if (r < 80)
        plen = $urandom_range(1, 6);
      else if (r < 95)
        plen = $urandom_range(7, MAX_PATTERN);
      else
        plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
      repeat (plen) begin
        c = pick_letter(alphabet);
        pattern_codes.push_back(c);
        send_item(FUNC_PATTERN, c);
      end
      tlen = $urandom_range(4, 40);
      n = 0;
      while (n < tlen) begin
        if ($urandom_range(3) == 0) begin
          foreach (pattern_codes[i]) send_item(FUNC_TEXT, pattern_codes[i]);
          n += pattern_codes.size();
        end else begin
          send_item(FUNC_TEXT, pick_letter(alphabet));
          n++;
        end
      end
    end else if (r < 85) begin
      // raw noise over every code and letter value
      repeat ($urandom_range(1, 8))
        send_item(2'($urandom_range(3)), 7'($urandom_range(127)));
    end else begin
      // pattern and text letters interleaved
      repeat ($urandom_range(2, 12))
        send_item(2'($urandom_range(1, 2)), pick_letter(2));
    end
  endtask

  initial begin
    int unsigned idle_set  [4];
    int unsigned stall_set [4];
    int unsigned target;

    idle_set  = '{0, 85, 0, 7};
    stall_set = '{0, 0, 85, 7};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-window match, sliding match, unused code, empty pattern,
    // extreme letter codes
    send_item(FUNC_CLEAR, 7'h7F);
    send_item(FUNC_PATTERN, CODE_A);
    send_item(FUNC_PATTERN, CODE_A + 7'd1);
    send_item(FUNC_TEXT, CODE_A);
    send_item(FUNC_TEXT, CODE_A + 7'd1);
    send_item(FUNC_TEXT, CODE_A);
    send_item(FUNC_TEXT, CODE_A + 7'd1);
    send_item(FUNC_UNUSED, 7'h55);
    send_item(FUNC_CLEAR, 7'h00);
    send_item(FUNC_TEXT, CODE_A + 7'd2);
    send_item(FUNC_TEXT, CODE_A + 7'd3);
    send_item(FUNC_PATTERN, 7'h00);
    send_item(FUNC_PATTERN, 7'h7F);
    send_item(FUNC_TEXT, 7'h00);
    send_item(FUNC_TEXT, 7'h7F);
    send_item(FUNC_TEXT, 7'h00);
    send_item(FUNC_TEXT, CODE_A + 7'd25);
    send_item(FUNC_CLEAR, 7'h2A);

    // Random sequences under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      target = items_sent + 500;
      while (items_sent < target) run_sequence();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give stray results a chance to show
    do @(negedge clk); while (results_due != 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ rolling_hash_substring_matcher.f @@
src/rhsm_pkg.sv
src/rhsm_ram.sv
src/rhsm_mulmod.sv
src/rhsm_front.sv
src/rhsm_back.sv
src/rolling_hash_substring_matcher.sv
tb/match_start_checker.sv
tb/rolling_hash_substring_matcher_test.sv
